/* rtl/bdlp_pkg.sv */
// bdlp_pkg: shared types and constants for the button debouncer with long press
// no dependencies
package bdlp_pkg;

    localparam int DEB_W       = 4;
    localparam int LPT_W       = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int DEB_RESET   = 2;
    localparam int LPT_RESET   = 70;
    localparam int LPE_RESET   = 6;

    localparam logic [LPT_W-1:0] HOLD_MAX = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DEBOUNCE_COUNT    = 2'd0,
        REG_LONG_PRESS_TICKS  = 2'd1,
        REG_LONG_PRESS_ENABLE = 2'd2
    } cfg_reg_t;

    // what one lane reports for the current tick
    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic active;
    } lane_out_t;

endpackage

/* rtl/bdlp_lane.sv */
// bdlp_lane: debounce and long-press tracking for one button
// depends on bdlp_pkg
module bdlp_lane
    import bdlp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick_en,
    input  logic             raw_level,
    input  logic             lp_en,
    input  logic [DEB_W-1:0] need,
    input  logic [LPT_W-1:0] lp_ticks,
    output lane_out_t        lane_out
);

    logic             committed_reg, committed_next;
    logic [DEB_W-1:0] mism_reg, mism_next;
    logic [LPT_W-1:0] hold_reg, hold_next;
    logic             done_reg, done_next;
    logic [DEB_W:0]   mism_inc;
    logic [LPT_W-1:0] hold_inc;

    always_comb begin
        committed_next    = committed_reg;
        mism_next         = mism_reg;
        hold_next         = hold_reg;
        done_next         = done_reg;
        lane_out.short_ev = 1'b0;
        lane_out.long_ev  = 1'b0;
        mism_inc          = {1'b0, mism_reg} + 1'b1;
        hold_inc          = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;

        if (raw_level == committed_reg) begin
            mism_next = '0;
            if (lp_en && !committed_reg) begin
                hold_next = hold_inc;
                if (!done_reg && hold_inc >= lp_ticks) begin
                    lane_out.long_ev = 1'b1;
                    done_next        = 1'b1;
                end
            end
        end else if (mism_inc >= {1'b0, need}) begin
            committed_next = raw_level;
            mism_next      = '0;
            if (!lp_en) begin
                lane_out.short_ev = !raw_level;
            end else if (!raw_level) begin
                hold_next = '0;
                done_next = 1'b0;
            end else begin
                lane_out.short_ev = !done_reg;
            end
        end else begin
            mism_next = mism_inc[DEB_W-1:0];
        end

        lane_out.active = !committed_next || (mism_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            committed_reg <= 1'b1;
            mism_reg      <= '0;
            hold_reg      <= '0;
            done_reg      <= 1'b0;
        end else if (tick_en) begin
            committed_reg <= committed_next;
            mism_reg      <= mism_next;
            hold_reg      <= hold_next;
            done_reg      <= done_next;
        end
    end

endmodule

/* rtl/bdlp_merge.sv */
// bdlp_merge: gathers the lane results into one result transaction and holds it
// in the output register until taken; depends on bdlp_pkg
module bdlp_merge
    import bdlp_pkg::*;
#(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    tick_en,
    input  logic [BUTTON_COUNT-1:0] short_vec,
    input  logic [BUTTON_COUNT-1:0] long_vec,
    input  logic [BUTTON_COUNT-1:0] active_vec,
    output logic                    in_ready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [BUTTON_COUNT-1:0] short_q,
    output logic [BUTTON_COUNT-1:0] long_q,
    output logic                    active_q
);

    logic valid_reg;

    // a tick may land while the register is empty or its result leaves this cycle
    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= tick_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            short_q  <= short_vec;
            long_q   <= long_vec;
            active_q <= |active_vec;
        end
    end

endmodule

/* rtl/button_debounce_long_press.sv */
// button_debounce_long_press: debouncer with short and long press events
// per button; depends on bdlp_pkg, bdlp_lane and bdlp_merge
//
// Each input transaction on s_ is one poll tick carrying the sampled
// active-low button levels. Every tick gives exactly one result transaction on
// m_ with the short and long event masks and the any-active flag.
// One lane per button updates its debounce and hold state in the accept cycle;
// the merge stage registers the combined result, so a result appears on m_
// in the cycle after its tick is accepted. One tick per cycle is sustained
// while the receiver takes every result; the single output register sets it.
// When the receiver stalls the result waits in the output register; s_tready
// stays high while that register is empty or being emptied in the same cycle.
// The cfg_ port writes debounce_count (0), long_press_ticks (1) and
// long_press_enable (2); write it only while no tick is in flight.
// Reset (aresetn low, synchronous) sets every button released with cleared
// counts, the registers to 2, 70 and 6, and empties the output register.
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // [BUTTON_COUNT-1:0] button_levels, zero padded to bytes
    input  logic [((BUTTON_COUNT+7)/8)*8-1:0]             s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // short_events, long_events, any_active from bit 0 up, zero padded to bytes
    output logic [((2*BUTTON_COUNT+8)/8)*8-1:0]           m_tdata,
    input  logic                                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                         cfg_addr,
    input  logic [((BUTTON_COUNT > LPT_W) ? BUTTON_COUNT : LPT_W)-1:0] cfg_wr_data
);

    localparam int InW  = ((BUTTON_COUNT+7)/8)*8;
    localparam int OutW = ((2*BUTTON_COUNT+8)/8)*8;
    localparam logic [BUTTON_COUNT-1:0] LpeRst = BUTTON_COUNT'(LPE_RESET);

    logic [DEB_W-1:0]        deb_reg;
    logic [LPT_W-1:0]        lpt_reg;
    logic [BUTTON_COUNT-1:0] lpe_reg;
    logic [DEB_W-1:0]        need;
    logic                    tick_en;
    logic                    in_ready;
    logic [BUTTON_COUNT-1:0] short_vec, long_vec, active_vec;
    logic [BUTTON_COUNT-1:0] short_q, long_q;
    logic                    active_q;
    lane_out_t               lane_res [BUTTON_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg <= DEB_W'(DEB_RESET);
            lpt_reg <= LPT_W'(LPT_RESET);
            lpe_reg <= LpeRst;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DEBOUNCE_COUNT:    deb_reg <= cfg_wr_data[DEB_W-1:0];
                REG_LONG_PRESS_TICKS:  lpt_reg <= cfg_wr_data[LPT_W-1:0];
                REG_LONG_PRESS_ENABLE: lpe_reg <= cfg_wr_data[BUTTON_COUNT-1:0];
                default: ;
            endcase
        end
    end

    // a count of zero behaves as one
    assign need     = (deb_reg == '0) ? DEB_W'(1) : deb_reg;
    assign s_tready = in_ready;
    assign tick_en  = s_tvalid && in_ready;

    for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
        bdlp_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tick_en   (tick_en),
            .raw_level (s_tdata[i]),
            .lp_en     (lpe_reg[i]),
            .need      (need),
            .lp_ticks  (lpt_reg),
            .lane_out  (lane_res[i])
        );
        assign short_vec[i]  = lane_res[i].short_ev;
        assign long_vec[i]   = lane_res[i].long_ev;
        assign active_vec[i] = lane_res[i].active;
    end

    bdlp_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (tick_en),
        .short_vec  (short_vec),
        .long_vec   (long_vec),
        .active_vec (active_vec),
        .in_ready   (in_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .short_q    (short_q),
        .long_q     (long_q),
        .active_q   (active_q)
    );

    assign m_tdata = OutW'({active_q, long_q, short_q});

    // padding bits of the input word carry nothing
    logic unused_pad;
    assign unused_pad = ^{1'b0, s_tdata[InW-1:0]};

endmodule

/* tb/sv/bdlp_checker.sv */
// bdlp_checker: watches the tick and result channels and the register port of
// the button debouncer, predicts every result and compares it; needs bdlp_pkg
`timescale 1ns / 100ps
module bdlp_checker
    import bdlp_pkg::*;
#(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    input  logic                                          s_tready,
    // button_levels from bit 0 up
    input  logic [((BUTTON_COUNT+7)/8)*8-1:0]             s_tdata,
    input  logic                                          m_tvalid,
    input  logic                                          m_tready,
    // short_events, long_events, any_active from bit 0 up
    input  logic [((2*BUTTON_COUNT+8)/8)*8-1:0]           m_tdata,
    input  logic                                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]                         cfg_addr,
    input  logic [((BUTTON_COUNT > LPT_W) ? BUTTON_COUNT : LPT_W)-1:0] cfg_wr_data,
    output int                                            error_count,
    output int                                            outstanding
);

    typedef logic [BUTTON_COUNT-1:0] mask_t;

    typedef struct packed {
        mask_t short_mask;
        mask_t long_mask;
        logic  active;
    } tick_events_t;

    logic [DEB_W-1:0] debounce_need_cfg;
    logic [LPT_W-1:0] long_ticks_cfg;
    mask_t            long_enable_cfg;

    mask_t            level_now;
    logic [DEB_W-1:0] bounce_cnt [BUTTON_COUNT];
    logic [LPT_W-1:0] held_ticks [BUTTON_COUNT];
    mask_t            long_fired;

    tick_events_t expected_events [$];
    int fail_total = 0;
    int queued     = 0;

    assign error_count = fail_total;
    assign outstanding = queued;

    // advances the per-button state by one poll tick and returns its events
    function automatic tick_events_t debounce_tick(input mask_t levels);
        tick_events_t     ev;
        logic [DEB_W-1:0] need;
        ev   = '0;
        need = (debounce_need_cfg == '0) ? DEB_W'(1) : debounce_need_cfg;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            if (levels[b] == level_now[b]) begin
                bounce_cnt[b] = '0;
                if (long_enable_cfg[b] && !level_now[b]) begin
                    if (held_ticks[b] != HOLD_MAX)
                        held_ticks[b] = held_ticks[b] + 1'b1;
                    if (!long_fired[b] && held_ticks[b] >= long_ticks_cfg) begin
                        ev.long_mask[b] = 1'b1;
                        long_fired[b]   = 1'b1;
                    end
                end
            end else begin
                bounce_cnt[b] = bounce_cnt[b] + 1'b1;
                if (bounce_cnt[b] >= need) begin
                    level_now[b]  = levels[b];
                    bounce_cnt[b] = '0;
                    if (!long_enable_cfg[b]) begin
                        ev.short_mask[b] = !levels[b];
                    end else if (!levels[b]) begin
                        held_ticks[b] = '0;
                        long_fired[b] = 1'b0;
                    end else if (!long_fired[b]) begin
                        // release after a hold that never reached the long event
                        ev.short_mask[b] = 1'b1;
                    end
                end
            end
            if (!level_now[b] || bounce_cnt[b] != '0)
                ev.active = 1'b1;
        end
        return ev;
    endfunction

    function automatic void report_failure(input string what, input tick_events_t want,
                                           input tick_events_t got);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t: %s: expected short=%b long=%b active=%b, %s",
                     $time, what, want.short_mask, want.long_mask, want.active,
                     $sformatf("got short=%b long=%b active=%b",
                               got.short_mask, got.long_mask, got.active));
    endfunction

    always @(posedge aclk) begin
        tick_events_t want;
        tick_events_t got;
        if (!aresetn) begin
            debounce_need_cfg <= DEB_W'(DEB_RESET);
            long_ticks_cfg    <= LPT_W'(LPT_RESET);
            long_enable_cfg   <= BUTTON_COUNT'(LPE_RESET);
            level_now         <= '1;
            long_fired        <= '0;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                bounce_cnt[b] <= '0;
                held_ticks[b] <= '0;
            end
            expected_events.delete();
            queued <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.short_mask = m_tdata[BUTTON_COUNT-1:0];
                got.long_mask  = m_tdata[2*BUTTON_COUNT-1:BUTTON_COUNT];
                got.active     = m_tdata[2*BUTTON_COUNT];
                if (expected_events.size() == 0) begin
                    report_failure("result with no tick pending", '0, got);
                end else begin
                    want = expected_events.pop_front();
                    if (got.short_mask != want.short_mask || got.long_mask != want.long_mask
                        || got.active != want.active)
                        report_failure("result mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
                expected_events.push_back(debounce_tick(s_tdata[BUTTON_COUNT-1:0]));
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DEBOUNCE_COUNT:    debounce_need_cfg = cfg_wr_data[DEB_W-1:0];
                    REG_LONG_PRESS_TICKS:  long_ticks_cfg    = cfg_wr_data[LPT_W-1:0];
                    REG_LONG_PRESS_ENABLE: long_enable_cfg   = cfg_wr_data[BUTTON_COUNT-1:0];
                    default: ;
                endcase
            end
            queued <= expected_events.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus and verdict for button_debounce_long_press; the bdlp_checker
// instance does all prediction and comparison; needs bdlp_pkg and the RTL
`timescale 1ns / 100ps
module tb_top;
    import bdlp_pkg::*;

    localparam int BUTTON_COUNT = 3;
    localparam int SDATA_W      = ((BUTTON_COUNT+7)/8)*8;
    localparam int MDATA_W      = ((2*BUTTON_COUNT+8)/8)*8;
    localparam int CDATA_W      = (BUTTON_COUNT > LPT_W) ? BUTTON_COUNT : LPT_W;
    localparam int ITEM_TARGET  = 1000;
    localparam int PHASE_ITEMS  = 100;
    // index outside the register map, writes to it must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [SDATA_W-1:0]    s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [MDATA_W-1:0]    m_tdata;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CDATA_W-1:0]    cfg_wr_data = '0;

    int fail_count;
    int in_flight;
    bit burst_mode = 1'b0;
    int deb_now    = DEB_RESET;
    int lpt_now    = LPT_RESET;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    button_debounce_long_press #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    bdlp_checker #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .error_count (fail_count),
        .outstanding (in_flight)
    );

    // one poll tick; returns at the edge where the transaction is taken
    task automatic send_tick(input logic [BUTTON_COUNT-1:0] levels);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SDATA_W-BUTTON_COUNT){1'b0}}, levels};
        do @(posedge aclk); while (!s_tready);
    endtask

    // the extra edge lets the checker count a transaction taken at the last edge
    task automatic wait_drained();
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
    endtask

    task automatic program_settings(input int deb, input int lpt, input int lpe);
        s_tvalid <= 1'b0;
        wait_drained();
        // upper data bits carry junk that the block has to drop
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_DEBOUNCE_COUNT;
        cfg_wr_data <= {4'($urandom), 4'(deb)};
        @(posedge aclk);
        cfg_addr    <= REG_LONG_PRESS_TICKS;
        cfg_wr_data <= 8'(lpt);
        @(posedge aclk);
        cfg_addr    <= REG_LONG_PRESS_ENABLE;
        cfg_wr_data <= {5'($urandom), 3'(lpe)};
        @(posedge aclk);
        cfg_addr    <= REG_SPARE;
        cfg_wr_data <= 8'($urandom);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        deb_now = deb;
        lpt_now = lpt;
    endtask

    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        logic [BUTTON_COUNT-1:0] default_seq [11];
        logic [BUTTON_COUNT-1:0] quick_seq [7];
        logic [BUTTON_COUNT-1:0] held;
        logic [BUTTON_COUNT-1:0] sample;
        int sent;
        int phase;
        int phase_len;
        int seg_len;
        int seg_kind;
        int idx;

        default_seq = '{3'b111, 3'b000, 3'b000, 3'b000, 3'b111, 3'b000,
                        3'b111, 3'b111, 3'b110, 3'b101, 3'b011};
        quick_seq   = '{3'b000, 3'b000, 3'b111, 3'b000, 3'b111, 3'b010, 3'b101};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: presses, a glitch and single-button patterns
        foreach (default_seq[i]) send_tick(default_seq[i]);

        // zero debounce count acts as one, zero long-press ticks fires on first hold
        program_settings(0, 0, 7);
        foreach (quick_seq[i]) send_tick(quick_seq[i]);

        // hold past the longest long-press time into saturation, then
        // change the enable mask while the buttons stay held
        program_settings(15, 255, 7);
        burst_mode = 1'b1;
        repeat (320) send_tick(3'b000);
        program_settings(15, 255, 2);
        repeat (5) send_tick(3'b000);
        program_settings(1, 255, 7);
        repeat (3) send_tick(3'b000);
        repeat (2) send_tick(3'b111);
        burst_mode = 1'b0;

        sent  = 0;
        phase = 0;
        while (sent < ITEM_TARGET) begin
            case (phase)
                0:       program_settings(1, 1, 7);
                1:       program_settings(15, 20, 0);
                2:       program_settings(0, 0, 5);
                3:       program_settings(2, 255, 7);
                default: program_settings($urandom_range(0, 15),
                                          ($urandom_range(0, 3) == 0) ?
                                          $urandom_range(0, 255) : $urandom_range(0, 24),
                                          $urandom_range(0, 7));
            endcase
            burst_mode = (phase % 3 == 2);
            phase_len  = 0;
            while (phase_len < PHASE_ITEMS) begin
                seg_kind = $urandom_range(0, 7);
                held     = BUTTON_COUNT'($urandom);
                if (seg_kind == 0) begin
                    // raw noise
                    seg_len = $urandom_range(1, 8);
                    repeat (seg_len) send_tick(BUTTON_COUNT'($urandom));
                end else begin
                    // a steady pattern with occasional contact bounce, held either
                    // briefly or for at least the long-press tick count
                    if (seg_kind < 4)
                        seg_len = $urandom_range(1, deb_now + 2);
                    else
                        seg_len = $urandom_range(lpt_now, lpt_now + deb_now + 4);
                    repeat (seg_len) begin
                        sample = held;
                        if ($urandom_range(0, 15) == 0) begin
                            idx = $urandom_range(0, BUTTON_COUNT - 1);
                            sample[idx] = !sample[idx];
                        end
                        send_tick(sample);
                    end
                end
                phase_len += seg_len;
            end
            sent += phase_len;
            phase++;
        end

        s_tvalid <= 1'b0;
        burst_mode = 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && in_flight == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
